// ===== rtl/sinv_pkg.sv =====
// Package for the symmetric 3x3 inverse pipeline.
// Holds the data widths and payload types shared by all rtl files; depends on nothing.
package sinv_pkg;

  // entry format: signed fixed point
  localparam int DATA_W = 32;
  localparam int FRAC_W = 16;

  // exact widths of the intermediates
  localparam int PROD_W = 2 * DATA_W;
  localparam int COF_W  = 2 * DATA_W + 1;
  localparam int CL_W   = DATA_W + 1;
  localparam int CH_W   = COF_W - CL_W;
  localparam int PL_W   = DATA_W + CL_W + 1;
  localparam int PH_W   = DATA_W + CH_W;
  localparam int DET_W  = 3 * DATA_W + 3;

  // divider widths
  localparam int SH_W   = 2 * FRAC_W + 1;
  localparam int NUM_W  = ((COF_W + SH_W > DET_W) ? (COF_W + SH_W) : DET_W) + 1;
  localparam int D2_W   = DET_W + 1;
  localparam int QB     = DATA_W;
  localparam int HI_W   = NUM_W - QB;
  localparam int CMP_W  = (HI_W > D2_W) ? HI_W : D2_W;

  // pipeline depth: input, products, cofactors, partials, det, divider
  localparam int DIV_LAT = QB + 3;
  localparam int LAT     = 5 + DIV_LAT;

  typedef logic signed [DATA_W-1:0] data_t;
  typedef logic signed [COF_W-1:0]  cof_t;
  typedef logic signed [DET_W-1:0]  det_t;

endpackage

// ===== rtl/symmetric_inverse_3x3_top.sv =====
// Symmetric 3x3 inverse, Q16.16: out_valid flags each result beat, carried down the valid bits from start.
// Throughput is one matrix per cycle; busy stays low, the pipeline never stalls.
// The depth is set by the divider, one quotient bit per stage for each of six entries.
// Synchronous active-low reset clears the valid bits; the data path is not reset.
// Depends on sinv_pkg, sinv_cof, sinv_det and sinv_div.
module symmetric_inverse_3x3_top (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        start,
  output logic                        busy,
  input  logic [sinv_pkg::DATA_W-1:0] in_a_00,
  input  logic [sinv_pkg::DATA_W-1:0] in_a_01,
  input  logic [sinv_pkg::DATA_W-1:0] in_a_02,
  input  logic [sinv_pkg::DATA_W-1:0] in_a_11,
  input  logic [sinv_pkg::DATA_W-1:0] in_a_12,
  input  logic [sinv_pkg::DATA_W-1:0] in_a_22,
  output logic                        out_valid,
  output logic [sinv_pkg::DATA_W-1:0] out_inv_00,
  output logic [sinv_pkg::DATA_W-1:0] out_inv_01,
  output logic [sinv_pkg::DATA_W-1:0] out_inv_02,
  output logic [sinv_pkg::DATA_W-1:0] out_inv_11,
  output logic [sinv_pkg::DATA_W-1:0] out_inv_12,
  output logic [sinv_pkg::DATA_W-1:0] out_inv_22,
  output logic                        out_singular,
  output logic                        out_saturated
);

  localparam int L  = sinv_pkg::LAT;
  localparam int SD = sinv_pkg::DIV_LAT;
  localparam int W  = sinv_pkg::DATA_W;

  logic            acc;
  logic [L-1:0]    vld_r, vld_nxt;
  logic [SD-1:0]   sing_r;
  sinv_pkg::data_t a_r [6];
  sinv_pkg::cof_t  cof [6];
  sinv_pkg::cof_t  cof_d_r [6];
  sinv_pkg::cof_t  cof_q_r [6];
  sinv_pkg::data_t row0 [3];
  sinv_pkg::cof_t  cof_row0 [3];
  sinv_pkg::det_t  det;
  logic [W-1:0]    res [6];
  logic [5:0]      sat;

  assign busy = 1'b0;
  assign acc  = start && !busy;

  // advance the valid bits every cycle
  assign vld_nxt = {vld_r[L-2:0], acc};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else begin
      vld_r <= vld_nxt;
    end
  end

  // capture the input beat
  always_ff @(posedge clk) begin
    a_r[0] <= in_a_00;
    a_r[1] <= in_a_01;
    a_r[2] <= in_a_02;
    a_r[3] <= in_a_11;
    a_r[4] <= in_a_12;
    a_r[5] <= in_a_22;
  end

  sinv_cof u_cof (
    .clk   (clk),
    .a00_i (a_r[0]),
    .a01_i (a_r[1]),
    .a02_i (a_r[2]),
    .a11_i (a_r[3]),
    .a12_i (a_r[4]),
    .a22_i (a_r[5]),
    .cof_o (cof),
    .a00_o (row0[0]),
    .a01_o (row0[1]),
    .a02_o (row0[2])
  );

  assign cof_row0[0] = cof[0];
  assign cof_row0[1] = cof[1];
  assign cof_row0[2] = cof[2];

  sinv_det u_det (
    .clk   (clk),
    .a_i   (row0),
    .cof_i (cof_row0),
    .det_o (det)
  );

  // hold the cofactors until the determinant is ready
  always_ff @(posedge clk) begin
    cof_d_r <= cof;
    cof_q_r <= cof_d_r;
  end

  for (genvar k = 0; k < 6; k++) begin : g_div
    sinv_div u_div (
      .clk   (clk),
      .cof_i (cof_q_r[k]),
      .det_i (det),
      .res_o (res[k]),
      .sat_o (sat[k])
    );
  end

  // carry the singular flag alongside the divider
  always_ff @(posedge clk) begin
    sing_r <= {sing_r[SD-2:0], (det == '0)};
  end

  // drop the entries of a singular matrix
  assign out_valid     = vld_r[L-1];
  assign out_singular  = sing_r[SD-1];
  assign out_saturated = !sing_r[SD-1] && (|sat);
  assign out_inv_00    = sing_r[SD-1] ? '0 : res[0];
  assign out_inv_01    = sing_r[SD-1] ? '0 : res[1];
  assign out_inv_02    = sing_r[SD-1] ? '0 : res[2];
  assign out_inv_11    = sing_r[SD-1] ? '0 : res[3];
  assign out_inv_12    = sing_r[SD-1] ? '0 : res[4];
  assign out_inv_22    = sing_r[SD-1] ? '0 : res[5];

endmodule

// ===== rtl/sinv_cof.sv =====
// Cofactor stages: twelve registered products, then six registered cofactors.
// Depends on sinv_pkg.
module sinv_cof (
  input  logic            clk,
  input  sinv_pkg::data_t a00_i,
  input  sinv_pkg::data_t a01_i,
  input  sinv_pkg::data_t a02_i,
  input  sinv_pkg::data_t a11_i,
  input  sinv_pkg::data_t a12_i,
  input  sinv_pkg::data_t a22_i,
  output sinv_pkg::cof_t  cof_o [6],
  output sinv_pkg::data_t a00_o,
  output sinv_pkg::data_t a01_o,
  output sinv_pkg::data_t a02_o
);

  localparam int PW = sinv_pkg::PROD_W;

  logic signed [PW-1:0] p_r [12];
  sinv_pkg::data_t a00_r, a01_r, a02_r, a00_q_r, a01_q_r, a02_q_r;
  sinv_pkg::cof_t  cof_r [6];

  // form the products pairwise
  always_ff @(posedge clk) begin
    p_r[0]  <= a11_i * a22_i;
    p_r[1]  <= a12_i * a12_i;
    p_r[2]  <= a02_i * a12_i;
    p_r[3]  <= a01_i * a22_i;
    p_r[4]  <= a01_i * a12_i;
    p_r[5]  <= a11_i * a02_i;
    p_r[6]  <= a00_i * a22_i;
    p_r[7]  <= a02_i * a02_i;
    p_r[8]  <= a01_i * a02_i;
    p_r[9]  <= a00_i * a12_i;
    p_r[10] <= a00_i * a11_i;
    p_r[11] <= a01_i * a01_i;
    a00_r   <= a00_i;
    a01_r   <= a01_i;
    a02_r   <= a02_i;
  end

  // subtract each pair, one bit wider
  always_ff @(posedge clk) begin
    for (int k = 0; k < 6; k++) begin
      cof_r[k] <= {p_r[2*k][PW-1], p_r[2*k]} - {p_r[2*k+1][PW-1], p_r[2*k+1]};
    end
    a00_q_r <= a00_r;
    a01_q_r <= a01_r;
    a02_q_r <= a02_r;
  end

  assign cof_o = cof_r;
  assign a00_o = a00_q_r;
  assign a01_o = a01_q_r;
  assign a02_o = a02_q_r;

endmodule

// ===== rtl/sinv_det.sv =====
// Determinant stages: split partial products of row 0 by its cofactors, then sum.
// Depends on sinv_pkg.
module sinv_det (
  input  logic            clk,
  input  sinv_pkg::data_t a_i   [3],
  input  sinv_pkg::cof_t  cof_i [3],
  output sinv_pkg::det_t  det_o
);

  localparam int CLW = sinv_pkg::CL_W;
  localparam int CHW = sinv_pkg::CH_W;
  localparam int PLW = sinv_pkg::PL_W;
  localparam int PHW = sinv_pkg::PH_W;
  localparam int DW  = sinv_pkg::DET_W;

  logic signed [PLW-1:0] pl_r [3];
  logic signed [PHW-1:0] ph_r [3];
  sinv_pkg::det_t        det_r;
  sinv_pkg::det_t        term [3];

  // multiply each entry by the low and high halves of its cofactor
  always_ff @(posedge clk) begin
    for (int k = 0; k < 3; k++) begin
      pl_r[k] <= a_i[k] * $signed({1'b0, cof_i[k][CLW-1:0]});
      ph_r[k] <= a_i[k] * $signed(cof_i[k][CLW+CHW-1:CLW]);
    end
  end

  // recombine the halves
  always_comb begin
    for (int k = 0; k < 3; k++) begin
      term[k] = ({{(DW-PHW){ph_r[k][PHW-1]}}, ph_r[k]} <<< CLW)
              + {{(DW-PLW){pl_r[k][PLW-1]}}, pl_r[k]};
    end
  end

  // sum the expansion along row 0
  always_ff @(posedge clk) begin
    det_r <= term[0] + term[1] + term[2];
  end

  assign det_o = det_r;

endmodule

// ===== rtl/sinv_div.sv =====
// Pipelined restoring divider for one inverse entry: one quotient bit per stage,
// then round-to-nearest result with saturation. Depends on sinv_pkg.
module sinv_div (
  input  logic                        clk,
  input  sinv_pkg::cof_t              cof_i,
  input  sinv_pkg::det_t              det_i,
  output logic [sinv_pkg::DATA_W-1:0] res_o,
  output logic                        sat_o
);

  localparam int W    = sinv_pkg::DATA_W;
  localparam int CW   = sinv_pkg::COF_W;
  localparam int DW   = sinv_pkg::DET_W;
  localparam int SH   = sinv_pkg::SH_W;
  localparam int NW   = sinv_pkg::NUM_W;
  localparam int D2W  = sinv_pkg::D2_W;
  localparam int Q    = sinv_pkg::QB;
  localparam int HW   = sinv_pkg::HI_W;
  localparam int CMPW = sinv_pkg::CMP_W;

  logic [CW-1:0]  cmag;
  logic [DW-1:0]  dmag;
  logic [NW-1:0]  num_r;
  logic [D2W-1:0] d2_r;
  logic           neg_r;
  logic [CMPW-1:0] hi_x, d2_x;

  logic [D2W-1:0] rem_r [Q];
  logic [D2W-1:0] dv_r  [Q];
  logic [Q-1:0]   nl_r  [Q];
  logic [Q-1:0]   q_r   [Q+1];
  logic           sg_r  [Q+1];
  logic           ov_r  [Q+1];

  logic [Q-1:0]   lim;
  logic [Q-1:0]   mag;
  logic           clamp;
  logic [W-1:0]   res_r;
  logic           sat_r;

  // take magnitudes, scale the numerator and add half the divisor for rounding
  assign cmag = cof_i[CW-1] ? CW'(-cof_i) : CW'(cof_i);
  assign dmag = det_i[DW-1] ? DW'(-det_i) : DW'(det_i);

  always_ff @(posedge clk) begin
    num_r <= ({{(NW-CW){1'b0}}, cmag} << SH) + {{(NW-DW){1'b0}}, dmag};
    d2_r  <= {dmag, 1'b0};
    neg_r <= cof_i[CW-1] ^ det_i[DW-1];
  end

  // flag a quotient too big for the result bits, seed the remainder
  assign hi_x = {{(CMPW-HW){1'b0}}, num_r[NW-1:Q]};
  assign d2_x = {{(CMPW-D2W){1'b0}}, d2_r};

  always_ff @(posedge clk) begin
    rem_r[0] <= hi_x[D2W-1:0];
    dv_r[0]  <= d2_r;
    nl_r[0]  <= num_r[Q-1:0];
    q_r[0]   <= '0;
    sg_r[0]  <= neg_r;
    ov_r[0]  <= (hi_x >= d2_x);
  end

  // one quotient bit per stage, most significant first
  for (genvar k = 0; k < Q; k++) begin : g_step
    logic [D2W:0] rs;
    logic         ge;
    assign rs = {rem_r[k], nl_r[k][Q-1-k]};
    assign ge = (rs >= {1'b0, dv_r[k]});

    always_ff @(posedge clk) begin
      q_r[k+1]  <= {q_r[k][Q-2:0], ge};
      sg_r[k+1] <= sg_r[k];
      ov_r[k+1] <= ov_r[k];
    end

    if (k < Q - 1) begin : g_fwd
      always_ff @(posedge clk) begin
        rem_r[k+1] <= ge ? D2W'(rs - {1'b0, dv_r[k]}) : rs[D2W-1:0];
        dv_r[k+1]  <= dv_r[k];
        nl_r[k+1]  <= nl_r[k];
      end
    end
  end

  // clamp to the signed range and apply the sign
  assign lim   = (Q'(1) << (W - 1)) - Q'(!sg_r[Q]);
  assign clamp = ov_r[Q] || (q_r[Q] > lim);
  assign mag   = clamp ? lim : q_r[Q];

  always_ff @(posedge clk) begin
    res_r <= sg_r[Q] ? W'(-mag) : W'(mag);
    sat_r <= clamp;
  end

  assign res_o = res_r;
  assign sat_o = sat_r;

endmodule

// ===== tb/tb_symmetric_inverse_3x3_top.sv =====
// Testbench for symmetric_inverse_3x3_top: random and corner-case symmetric matrices
// checked against an exact-arithmetic predictor of the adjugate/determinant inverse.
// Depends on sinv_pkg and the rtl of the block.
module tb_symmetric_inverse_3x3_top;

  typedef struct {
    logic [sinv_pkg::DATA_W-1:0] a00, a01, a02, a11, a12, a22;
  } matrix_t;

  typedef struct {
    logic [sinv_pkg::DATA_W-1:0] inv [6];
    logic singular;
    logic saturated;
  } inverse_t;

  logic clk;
  logic rst_n;
  logic start;
  logic busy;
  logic [sinv_pkg::DATA_W-1:0] in_a_00, in_a_01, in_a_02, in_a_11, in_a_12, in_a_22;
  logic out_valid;
  logic [sinv_pkg::DATA_W-1:0] out_inv_00, out_inv_01, out_inv_02;
  logic [sinv_pkg::DATA_W-1:0] out_inv_11, out_inv_12, out_inv_22;
  logic out_singular, out_saturated;

  matrix_t  pending_mats [$];
  inverse_t expected_invs [$];
  int       fail_count;
  int       gap_pct;
  bit       hold_off;
  bit       stim_done;
  string    inv_names [6] = '{"inv_00", "inv_01", "inv_02", "inv_11", "inv_12", "inv_22"};

  symmetric_inverse_3x3_top dut (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
    .in_a_00(in_a_00), .in_a_01(in_a_01), .in_a_02(in_a_02),
    .in_a_11(in_a_11), .in_a_12(in_a_12), .in_a_22(in_a_22),
    .out_valid(out_valid),
    .out_inv_00(out_inv_00), .out_inv_01(out_inv_01), .out_inv_02(out_inv_02),
    .out_inv_11(out_inv_11), .out_inv_12(out_inv_12), .out_inv_22(out_inv_22),
    .out_singular(out_singular), .out_saturated(out_saturated)
  );

  // 20-unit clock
  always begin
    clk = 1'b0;
    #10;
    clk = 1'b1;
    #10;
  end

  // Round cofactor/det scaled by 2^(2F), ties away from zero, clamp to range
  function automatic logic [sinv_pkg::DATA_W-1:0] scaled_quotient(
      input logic signed [255:0] cof, input logic signed [255:0] det, inout logic sat);
    logic [255:0] num, mag_d, q, lim;
    logic neg;
    neg = cof[255] ^ det[255];
    num = cof[255] ? -cof : cof;
    mag_d = det[255] ? -det : det;
    num = (num << (2 * sinv_pkg::FRAC_W + 1)) + mag_d;
    q = num / (mag_d << 1);
    lim = (256'd1 << (sinv_pkg::DATA_W - 1)) - (neg ? 256'd0 : 256'd1);
    if (q > lim) begin
      q = lim;
      sat = 1'b1;
    end
    return neg ? -q[sinv_pkg::DATA_W-1:0] : q[sinv_pkg::DATA_W-1:0];
  endfunction

  // Predict the inverse of one symmetric matrix exactly
  function automatic inverse_t invert_symmetric(matrix_t m);
    logic signed [255:0] e00, e01, e02, e11, e12, e22, det;
    logic signed [255:0] cof [6];
    inverse_t r;
    logic sat;
    e00 = signed'(m.a00); e01 = signed'(m.a01); e02 = signed'(m.a02);
    e11 = signed'(m.a11); e12 = signed'(m.a12); e22 = signed'(m.a22);
    cof[0] = e11 * e22 - e12 * e12;
    cof[1] = e02 * e12 - e01 * e22;
    cof[2] = e01 * e12 - e11 * e02;
    cof[3] = e00 * e22 - e02 * e02;
    cof[4] = e01 * e02 - e00 * e12;
    cof[5] = e00 * e11 - e01 * e01;
    det = e00 * cof[0] + e01 * cof[1] + e02 * cof[2];
    sat = 1'b0;
    r.singular = (det == 0);
    for (int k = 0; k < 6; k++)
      r.inv[k] = r.singular ? '0 : scaled_quotient(cof[k], det, sat);
    r.saturated = r.singular ? 1'b0 : sat;
    return r;
  endfunction

  // Drive one beat per accepted cycle from the pending queue
  always @(posedge clk) begin
    if (!rst_n) begin
      start <= 1'b0;
    end else begin
      if (start && !busy) expected_invs.push_back(invert_symmetric(
          '{in_a_00, in_a_01, in_a_02, in_a_11, in_a_12, in_a_22}));
      if ((start && busy) ) begin
        // hold the beat
      end else if (pending_mats.size() > 0 && !hold_off &&
                   $urandom_range(99) >= gap_pct) begin
        matrix_t m;
        m = pending_mats.pop_front();
        start <= 1'b1;
        in_a_00 <= m.a00; in_a_01 <= m.a01; in_a_02 <= m.a02;
        in_a_11 <= m.a11; in_a_12 <= m.a12; in_a_22 <= m.a22;
      end else begin
        start <= 1'b0;
      end
    end
  end

  // Compare each result beat with the oldest prediction
  always @(posedge clk) begin
    if (rst_n && out_valid) begin
      if (expected_invs.size() == 0) begin
        $error("unexpected result beat");
        fail_count++;
      end else begin
        inverse_t e;
        logic [sinv_pkg::DATA_W-1:0] got [6];
        e = expected_invs.pop_front();
        got = '{out_inv_00, out_inv_01, out_inv_02, out_inv_11, out_inv_12, out_inv_22};
        for (int k = 0; k < 6; k++)
          if (got[k] !== e.inv[k]) begin
            $error("%s expected %h actual %h", inv_names[k], e.inv[k], got[k]);
            fail_count++;
          end
        if (out_singular !== e.singular) begin
          $error("singular expected %b actual %b", e.singular, out_singular);
          fail_count++;
        end
        if (out_saturated !== e.saturated) begin
          $error("saturated expected %b actual %b", e.saturated, out_saturated);
          fail_count++;
        end
      end
    end
  end

  function automatic logic [sinv_pkg::DATA_W-1:0] rand_entry();
    case ($urandom_range(5))
      0: return $urandom();
      1: return $urandom_range(3) << sinv_pkg::FRAC_W;
      2: return -($urandom_range(3) << sinv_pkg::FRAC_W);
      3: return $urandom_range(255) << ($urandom_range(20) + 4);
      4: return $urandom_range(7) - 3;
      default: return {$urandom_range(1) ? 8'hFF : 8'h00, 24'($urandom())};
    endcase
  endfunction

  task automatic wait_drained();
    while (pending_mats.size() > 0 || start || expected_invs.size() > 0) @(posedge clk);
  endtask

  // Directed corners, then random phases with varying sender gaps
  initial begin
    logic [sinv_pkg::DATA_W-1:0] one, mx, mn;
    fail_count = 0;
    gap_pct = 0;
    hold_off = 1'b0;
    stim_done = 1'b0;
    rst_n = 1'b0;
    start = 1'b0;
    {in_a_00, in_a_01, in_a_02, in_a_11, in_a_12, in_a_22} = '0;
    one = 1 << sinv_pkg::FRAC_W;
    mx = {1'b0, {(sinv_pkg::DATA_W-1){1'b1}}};
    mn = {1'b1, {(sinv_pkg::DATA_W-1){1'b0}}};
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    pending_mats.push_back('{one, 0, 0, one, 0, one});           // identity
    pending_mats.push_back('{0, 0, 0, 0, 0, 0});                 // zero, singular
    pending_mats.push_back('{one, one, one, one, one, one});     // rank one
    pending_mats.push_back('{mx, 0, 0, mx, 0, mx});              // tiny inverse
    pending_mats.push_back('{mn, 0, 0, mn, 0, mn});
    pending_mats.push_back('{1, 0, 0, 1, 0, 1});                 // huge inverse, clamp
    pending_mats.push_back('{-1, 0, 0, -1, 0, -1});
    pending_mats.push_back('{mx, mx, mx, mx, mx, mx});
    pending_mats.push_back('{mn, mx, mn, mx, mn, mx});
    pending_mats.push_back('{one, one >> 1, 0, one, one >> 1, one});
    pending_mats.push_back('{2 * one, 0, 0, 2 * one, 0, 2 * one}); // exact halves
    pending_mats.push_back('{3 * one, 0, 0, 3 * one, 0, 3 * one}); // rounding
    pending_mats.push_back('{'1, '1, '1, '1, '1, '1});
    wait_drained();
    // hold off the sender until every prediction is met
    hold_off = 1'b1;
    repeat (sinv_pkg::LAT + 5) @(posedge clk);
    hold_off = 1'b0;
    for (int ph = 0; ph < 4; ph++) begin
      gap_pct = (ph == 1) ? 46 : (ph == 3) ? 21 : 0;
      for (int i = 0; i < 475; i++)
        pending_mats.push_back('{rand_entry(), rand_entry(), rand_entry(),
                                 rand_entry(), rand_entry(), rand_entry()});
      wait_drained();
    end
    repeat (sinv_pkg::LAT + 10) @(posedge clk);
    if (fail_count == 0 && expected_invs.size() == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

  // Watchdog
  initial begin
    #4000000;
    $display("RESULT: ERROR");
    $finish;
  end

endmodule
